// ===== hw/rtl/tes_pkg.sv =====
`timescale 1ns / 1ps

package tes_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned ID_W = 32;
  localparam int unsigned TICKS_W = 24;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_IDX_W = 4;
  localparam int unsigned RES_CNT_W = 5;
  localparam int unsigned DIV_CNT_W = 6;
  localparam logic [DELAY_W-1:0] DELAY_SAT = 32'h7FFF_FFFF;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED    = 3'd0,
    KIND_FULL     = 3'd1,
    KIND_CANCELED = 3'd2,
    KIND_FIRED    = 3'd3,
    KIND_DELAY    = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD,
    ST_SCAN_ADDR,
    ST_SCAN_EVAL,
    ST_SCAN_DONE,
    ST_REARM,
    ST_REARM_WAIT,
    ST_REARM_WR,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic latch_in;
    logic scan_start;
    logic scan_next;
    logic scan_eval;
    logic add_exec;
    logic query_fin;
    logic fire_push;
    logic rearm_start;
    logic rearm_write;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic idx_last;
    logic best_found;
    logic best_periodic;
    logic res_full;
    logic res_empty;
    logic rem_ready;
    logic emit_last;
  } dp_sts_t;

endpackage

// ===== hw/rtl/timer_expiry_scheduler_core.sv =====
`timescale 1ns / 1ps

// Table of one-shot and periodic timers on a 48-bit tick counter. Each item is
// an add, cancel, tick or query command; add, cancel and query give one result
// item, a tick gives one fire item per due timer (at most 16, earliest first).
// Cancel, tick and query commands walk the timer table one slot at a time
// through the slot memory read port, an address state and an evaluate state
// per slot; add writes the lowest free slot without a walk. A tick rescans
// the table after each fire. Re-arming a periodic timer passes through the
// REARM, REARM_WAIT and REARM_WR states, and when the timer is late by a
// whole period or more the bit-serial remainder step runs in REARM_WAIT.
// Results are delivered one per cycle while the output is not stalled.
module timer_expiry_scheduler_core import tes_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [TICKS_W-1:0]        delay_ticks_i,
  input  logic [TICKS_W-1:0]        interval_ticks_i,
  input  logic [ID_W-1:0]           cancel_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                kind_o,
  output logic [ID_W-1:0]           result_id_o,
  output logic signed [DELAY_W-1:0] next_delay_o,
  output logic                      any_active_o,
  output logic                      last_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic signed [DELAY_W-1:0] cfg_data_i
);

  localparam int unsigned SLOT_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

  dp_cmd_t ctl;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  tes_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  tes_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .sts_o            (sts),
    .command_i        (command_i),
    .delay_ticks_i    (delay_ticks_i),
    .interval_ticks_i (interval_ticks_i),
    .cancel_id_i      (cancel_id_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .kind_o           (kind_o),
    .result_id_o      (result_id_o),
    .next_delay_o     (next_delay_o),
    .any_active_o     (any_active_o),
    .last_o           (last_o)
  );

endmodule

// ===== hw/rtl/tes_rem.sv =====
`timescale 1ns / 1ps

module tes_rem import tes_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [TIME_W-1:0]  dividend_i,
  input  logic [TICKS_W-1:0] divisor_i,
  output logic               done_o,
  output logic [TICKS_W-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]  quo_q, quo_d;
  logic [TICKS_W-1:0] rem_q, rem_d;
  logic [TICKS_W-1:0] div_q, div_d;
  logic [TICKS_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[TIME_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(TIME_W - 1);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = TICKS_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[TICKS_W-1:0];
      end
      quo_d = {quo_q[TIME_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/tes_datapath.sv =====
`timescale 1ns / 1ps

module tes_datapath import tes_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16,
  parameter int unsigned SLOT_W = 4
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dp_cmd_t                   ctl_i,
  output dp_sts_t                   sts_o,
  input  logic [1:0]                command_i,
  input  logic [TICKS_W-1:0]        delay_ticks_i,
  input  logic [TICKS_W-1:0]        interval_ticks_i,
  input  logic [ID_W-1:0]           cancel_id_i,
  input  logic                      cfg_valid_i,
  input  logic signed [DELAY_W-1:0] cfg_data_i,
  output logic [2:0]                kind_o,
  output logic [ID_W-1:0]           result_id_o,
  output logic signed [DELAY_W-1:0] next_delay_o,
  output logic                      any_active_o,
  output logic                      last_o
);

  cmd_e                  cmd_q;
  logic [TICKS_W-1:0]    delay_q;
  logic [TICKS_W-1:0]    interval_q;
  logic [ID_W-1:0]       tid_q;
  logic [TIME_W-1:0]     now_q;
  logic [ID_W-1:0]       next_id_q;
  logic [DELAY_W-1:0]    dflt_q;
  logic [TIMER_SLOTS-1:0] valid_q, valid_d;
  logic [SLOT_W-1:0]     idx_q;
  logic                  best_found_q;
  logic [SLOT_W-1:0]     best_idx_q;
  logic [TIME_W-1:0]     best_exp_q;
  logic [ID_W-1:0]       best_id_q;
  logic [TICKS_W-1:0]    best_per_q;
  logic [ID_W-1:0]       res_ids_q [MAX_RESULTS];
  logic [RES_CNT_W-1:0]  res_n_q;
  kind_e                 res_kind_q;
  logic [DELAY_W-1:0]    res_delay_q;
  logic [RES_IDX_W-1:0]  emit_k_q;
  logic [TICKS_W-1:0]    rem_q;
  logic                  rem_ready_q;

  logic [ID_W-1:0]       mem_id  [TIMER_SLOTS];
  logic [TIME_W-1:0]     mem_exp [TIMER_SLOTS];
  logic [TICKS_W-1:0]    mem_per [TIMER_SLOTS];
  logic [ID_W-1:0]       rd_id_q;
  logic [TIME_W-1:0]     rd_exp_q;
  logic [TICKS_W-1:0]    rd_per_q;

  logic                  free_found;
  logic [SLOT_W-1:0]     free_idx;
  logic                  cand;
  logic                  take;
  logic [TIME_W-1:0]     ahead;
  logic [DELAY_W-1:0]    query_d;
  logic [TIME_W-1:0]     late;
  logic                  late_small;
  logic                  div_done;
  logic [TICKS_W-1:0]    div_rem;
  logic [TIME_W-1:0]     rearm_exp;
  logic                  mem_we;
  logic                  mem_full_we;
  logic [SLOT_W-1:0]     mem_waddr;
  logic [TIME_W-1:0]     mem_wexp;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    if (cmd_q == CMD_TICK) begin
      cand = valid_q[idx_q] && (rd_exp_q <= now_q);
    end else begin
      cand = valid_q[idx_q];
    end
    take = cand && (!best_found_q || (rd_exp_q < best_exp_q));
  end

  always_comb begin
    ahead = best_exp_q - now_q;
    if (!best_found_q) begin
      query_d = dflt_q;
    end else if (best_exp_q <= now_q) begin
      query_d = DELAY_W'(1);
    end else if (ahead > {{(TIME_W-DELAY_W){1'b0}}, DELAY_SAT}) begin
      query_d = DELAY_SAT;
    end else begin
      query_d = ahead[DELAY_W-1:0];
    end
  end

  assign late       = now_q - best_exp_q;
  assign late_small = late < {{(TIME_W-TICKS_W){1'b0}}, best_per_q};
  assign rearm_exp  = now_q - {{(TIME_W-TICKS_W){1'b0}}, rem_q}
                    + {{(TIME_W-TICKS_W){1'b0}}, best_per_q};

  tes_rem u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctl_i.rearm_start && !late_small),
    .dividend_i (late),
    .divisor_i  (best_per_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign mem_full_we = ctl_i.add_exec && free_found;
  assign mem_we      = mem_full_we || ctl_i.rearm_write;
  assign mem_waddr   = ctl_i.rearm_write ? best_idx_q : free_idx;
  assign mem_wexp    = ctl_i.rearm_write ? rearm_exp
                     : now_q + {{(TIME_W-TICKS_W){1'b0}}, delay_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_exp[mem_waddr] <= mem_wexp;
    end
    if (mem_full_we) begin
      mem_id[mem_waddr]  <= next_id_q;
      mem_per[mem_waddr] <= interval_q;
    end
    rd_id_q  <= mem_id[idx_q];
    rd_exp_q <= mem_exp[idx_q];
    rd_per_q <= mem_per[idx_q];
  end

  always_comb begin
    valid_d = valid_q;
    if (mem_full_we) begin
      valid_d[free_idx] = 1'b1;
    end
    if (ctl_i.scan_eval && (cmd_q == CMD_CANCEL) && valid_q[idx_q] && (rd_id_q == tid_q)) begin
      valid_d[idx_q] = 1'b0;
    end
    if (ctl_i.fire_push && (best_per_q == '0)) begin
      valid_d[best_idx_q] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q      <= '0;
      now_q        <= '0;
      next_id_q    <= ID_W'(1);
      dflt_q       <= '1;
      cmd_q        <= CMD_ADD;
      idx_q        <= '0;
      best_found_q <= 1'b0;
      res_n_q      <= '0;
      emit_k_q     <= '0;
      rem_ready_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cfg_valid_i) begin
        dflt_q <= cfg_data_i;
      end
      if (ctl_i.latch_in) begin
        cmd_q    <= cmd_e'(command_i);
        res_n_q  <= (cmd_e'(command_i) == CMD_CANCEL) ? RES_CNT_W'(1) : '0;
        emit_k_q <= '0;
        if (cmd_e'(command_i) == CMD_TICK) begin
          now_q <= now_q + TIME_W'(1);
        end
      end
      if (ctl_i.add_exec) begin
        res_n_q <= RES_CNT_W'(1);
        if (free_found) begin
          next_id_q <= next_id_q + ID_W'(1);
        end
      end
      if (ctl_i.query_fin) begin
        res_n_q <= RES_CNT_W'(1);
      end
      if (ctl_i.fire_push) begin
        res_n_q <= res_n_q + RES_CNT_W'(1);
      end
      if (ctl_i.scan_start) begin
        idx_q        <= '0;
        best_found_q <= 1'b0;
      end else begin
        if (ctl_i.scan_next) begin
          idx_q <= idx_q + SLOT_W'(1);
        end
        if (ctl_i.scan_eval && take) begin
          best_found_q <= 1'b1;
        end
      end
      if (ctl_i.rearm_start) begin
        rem_ready_q <= late_small;
      end else if (div_done) begin
        rem_ready_q <= 1'b1;
      end
      if (ctl_i.emit_load) begin
        emit_k_q <= emit_k_q + RES_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch_in) begin
      delay_q     <= delay_ticks_i;
      interval_q  <= interval_ticks_i;
      tid_q       <= cancel_id_i;
      res_delay_q <= '0;
      unique case (cmd_e'(command_i))
        CMD_CANCEL: begin
          res_kind_q   <= KIND_CANCELED;
          res_ids_q[0] <= cancel_id_i;
        end
        CMD_TICK:   res_kind_q <= KIND_FIRED;
        default:    res_kind_q <= KIND_DELAY;
      endcase
    end
    if (ctl_i.add_exec) begin
      res_kind_q   <= free_found ? KIND_ADDED : KIND_FULL;
      res_ids_q[0] <= free_found ? next_id_q : '0;
    end
    if (ctl_i.query_fin) begin
      res_kind_q   <= KIND_DELAY;
      res_ids_q[0] <= '0;
      res_delay_q  <= query_d;
    end
    if (ctl_i.fire_push) begin
      res_ids_q[res_n_q[RES_IDX_W-1:0]] <= best_id_q;
    end
    if (ctl_i.scan_eval && take) begin
      best_idx_q <= idx_q;
      best_exp_q <= rd_exp_q;
      best_id_q  <= rd_id_q;
      best_per_q <= rd_per_q;
    end
    if (!ctl_i.rearm_start && div_done) begin
      rem_q <= div_rem;
    end else if (ctl_i.rearm_start) begin
      rem_q <= late[TICKS_W-1:0];
    end
    if (ctl_i.emit_load) begin
      kind_o       <= res_kind_q;
      result_id_o  <= res_ids_q[emit_k_q];
      next_delay_o <= res_delay_q;
      any_active_o <= |valid_q;
      last_o       <= sts_o.emit_last;
    end
  end

  always_comb begin
    sts_o.cmd           = cmd_q;
    sts_o.idx_last      = (idx_q == SLOT_W'(TIMER_SLOTS - 1));
    sts_o.best_found    = best_found_q;
    sts_o.best_periodic = (best_per_q != '0);
    sts_o.res_full      = (res_n_q == RES_CNT_W'(MAX_RESULTS));
    sts_o.res_empty     = (res_n_q == '0);
    sts_o.rem_ready     = rem_ready_q;
    sts_o.emit_last     = ({1'b0, emit_k_q} + RES_CNT_W'(1) == res_n_q);
  end

endmodule

// ===== hw/rtl/tes_ctrl.sv =====
`timescale 1ns / 1ps

module tes_ctrl import tes_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] command_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign can_load    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          ctl_o.latch_in   = 1'b1;
          ctl_o.scan_start = 1'b1;
          state_d = (cmd_e'(command_i) == CMD_ADD) ? ST_ADD : ST_SCAN_ADDR;
        end
      end
      ST_ADD: begin
        ctl_o.add_exec = 1'b1;
        state_d = ST_EMIT;
      end
      ST_SCAN_ADDR: state_d = ST_SCAN_EVAL;
      ST_SCAN_EVAL: begin
        ctl_o.scan_eval = 1'b1;
        if (sts_i.idx_last) begin
          state_d = ST_SCAN_DONE;
        end else begin
          ctl_o.scan_next = 1'b1;
          state_d = ST_SCAN_ADDR;
        end
      end
      ST_SCAN_DONE: begin
        unique case (sts_i.cmd)
          CMD_TICK: begin
            if (!sts_i.best_found || sts_i.res_full) begin
              state_d = sts_i.res_empty ? ST_IDLE : ST_EMIT;
            end else begin
              ctl_o.fire_push = 1'b1;
              if (sts_i.best_periodic) begin
                state_d = ST_REARM;
              end else begin
                ctl_o.scan_start = 1'b1;
                state_d = ST_SCAN_ADDR;
              end
            end
          end
          CMD_QUERY: begin
            ctl_o.query_fin = 1'b1;
            state_d = ST_EMIT;
          end
          default: state_d = ST_EMIT;
        endcase
      end
      ST_REARM: begin
        ctl_o.rearm_start = 1'b1;
        state_d = ST_REARM_WAIT;
      end
      ST_REARM_WAIT: begin
        if (sts_i.rem_ready) begin
          state_d = ST_REARM_WR;
        end
      end
      ST_REARM_WR: begin
        ctl_o.rearm_write = 1'b1;
        ctl_o.scan_start  = 1'b1;
        state_d = ST_SCAN_ADDR;
      end
      ST_EMIT: begin
        if (can_load) begin
          ctl_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (ctl_o.emit_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/tes_checker.sv =====
`timescale 1ns / 1ps

module tes_checker import tes_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [1:0]                command_i,
  input logic [TICKS_W-1:0]        delay_ticks_i,
  input logic [TICKS_W-1:0]        interval_ticks_i,
  input logic [ID_W-1:0]           cancel_id_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [2:0]                kind_o,
  input logic [ID_W-1:0]           result_id_o,
  input logic signed [DELAY_W-1:0] next_delay_o,
  input logic                      any_active_o,
  input logic                      last_o,
  input logic                      cfg_valid_i,
  input logic                      cfg_ready_o,
  input logic signed [DELAY_W-1:0] cfg_data_i
);

  // A stalled result item holds its valid and payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(kind_o)
      && $stable(result_id_o) && $stable(next_delay_o) && $stable(last_o)))
    else $error("stalled result item changed");

  // One command at a time: after an item is taken the input stalls.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // Only query results carry a delay.
  a_delay_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o != KIND_DELAY)) |-> (next_delay_o == '0))
    else $error("nonzero delay on a non-query result");

  // Query and full results carry no id and are the last item.
  a_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((kind_o == KIND_DELAY) || (kind_o == KIND_FULL)))
      |-> (result_id_o == '0) && last_o)
    else $error("query or full result with id or without last");

endmodule

bind timer_expiry_scheduler_core tes_checker u_tes_checker (.*);
